@@ rtl/core/tdfs_pkg.sv @@
// Shared types and constants for the triangle fragment depth shader core.
// No dependencies; used by every module under rtl/core.
package tdfs_pkg;

   localparam int SCREEN_WIDTH_DEF  = 1024;
   localparam int SCREEN_HEIGHT_DEF = 1024;

   localparam int DIFF_W = 17;               // coordinate differences
   localparam int ACC_W  = 40;               // edge functions and area
   localparam int PROD_W = ACC_W + DIFF_W;   // shared multiplier product
   localparam int DIV_W  = 54;               // divider numerator/denominator
   localparam int QUO_W  = 16;               // divider quotient

   localparam logic signed [16:0] QUO_OFFSET = 17'sd32768;
   localparam logic signed [16:0] FAR_DEPTH  = 17'sd16384;
   localparam logic signed [16:0] NEAR_DEPTH = -17'sd16384;
   localparam logic signed [16:0] COLOUR_MAX = 17'sd255;
   localparam logic [15:0]        FAR_WORD   = 16'h4000;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_FRAG = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      CH_DEPTH = 2'd0,
      CH_RED   = 2'd1,
      CH_GREEN = 2'd2,
      CH_BLUE  = 2'd3
   } chan_type;

   typedef struct packed {
      op_type             op;
      logic [1:0]         vertex_index;
      logic signed [15:0] vert_x;
      logic signed [15:0] vert_y;
      logic signed [15:0] vert_z;
      logic [7:0]         vert_red;
      logic [7:0]         vert_green;
      logic [7:0]         vert_blue;
      logic [9:0]         pixel_x;
      logic [9:0]         pixel_y;
   } item_type;

   typedef struct packed {
      logic pop;
      logic clearing;
   } ctl_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EDGE,
      ST_COVER,
      ST_MAC,
      ST_DSTART,
      ST_DWAIT,
      ST_MEMRD,
      ST_MEMCMP,
      ST_OUT
   } state_type;

endpackage

@@ rtl/core/tdfs_front.sv @@
// Front end: takes request transactions, drops vertex loads to index three,
// and queues the rest for the back end. Depends on tdfs_pkg.
module tdfs_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  tdfs_pkg::item_type req_item,
   input  tdfs_pkg::ctl_type  ctl,
   output logic               head_valid,
   output tdfs_pkg::item_type head
);

   tdfs_pkg::item_type q_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;
   logic               accept, keep, push, pop;

   assign req_stall  = (count_ff == 2'd2) || ctl.clearing;
   assign accept     = req_valid && !req_stall;
   assign keep       = (req_item.op == tdfs_pkg::OP_FRAG) || (req_item.vertex_index != 2'd3);
   assign push       = accept && keep;
   assign head_valid = (count_ff != 2'd0);
   assign pop        = ctl.pop && head_valid;
   assign head       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= req_item;
      end
   end

endmodule

@@ rtl/core/tdfs_div.sv @@
// Restoring divider, one quotient bit per cycle, for the interpolation ratios.
// Depends on tdfs_pkg.
module tdfs_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [tdfs_pkg::DIV_W-1:0]   num,
   input  logic [tdfs_pkg::DIV_W-1:0]   den,
   output logic                         done,
   output logic [tdfs_pkg::QUO_W-1:0]   quo
);

   localparam int CNT_W = $clog2(tdfs_pkg::QUO_W);

   logic [tdfs_pkg::DIV_W-1:0] rem_ff, dsh_ff;
   logic [tdfs_pkg::QUO_W-1:0] quo_ff;
   logic [CNT_W-1:0]           cnt_ff;
   logic                       busy_ff, done_ff;
   logic                       ge;

   assign ge   = (rem_ff >= dsh_ff);
   assign done = done_ff;
   assign quo  = quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(tdfs_pkg::QUO_W - 1);
         end else if (busy_ff) begin
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= num;
         dsh_ff <= den << (tdfs_pkg::QUO_W - 1);
         quo_ff <= '0;
      end else if (busy_ff) begin
         if (ge) begin
            rem_ff <= rem_ff - dsh_ff;
         end
         quo_ff <= {quo_ff[tdfs_pkg::QUO_W-2:0], ge};
         dsh_ff <= dsh_ff >> 1;
      end
   end

endmodule

@@ rtl/core/tdfs_back.sv @@
// Back end: vertex store, edge functions, coverage, interpolation through a
// shared multiplier and divider, and the depth buffer. Depends on tdfs_pkg, tdfs_div.
module tdfs_back #(
   parameter int SCREEN_WIDTH  = tdfs_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = tdfs_pkg::SCREEN_HEIGHT_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  tdfs_pkg::item_type head,
   output tdfs_pkg::ctl_type  ctl,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_covered,
   output logic               rsp_written,
   output logic [9:0]         rsp_out_x,
   output logic [9:0]         rsp_out_y,
   output logic [7:0]         rsp_out_red,
   output logic [7:0]         rsp_out_green,
   output logic [7:0]         rsp_out_blue,
   output logic signed [15:0] rsp_out_depth
);

   localparam int DEPTH_ENTRIES = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int ADDR_W        = $clog2(DEPTH_ENTRIES);
   localparam int ACC_W         = tdfs_pkg::ACC_W;
   localparam int DW            = tdfs_pkg::DIFF_W;
   localparam int DIV_W         = tdfs_pkg::DIV_W;

   tdfs_pkg::state_type state_ff, state_in;

   logic signed [15:0] vx_ff [3];
   logic signed [15:0] vy_ff [3];
   logic signed [15:0] vz_ff [3];
   logic [7:0]         cr_ff [3];
   logic [7:0]         cg_ff [3];
   logic [7:0]         cb_ff [3];
   logic [9:0]         px_ff, py_ff;
   logic [2:0]         step_ff;
   logic [1:0]         ch_ff;
   logic signed [tdfs_pkg::PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0] d_ff, w0_ff, w1_ff, dabs_ff;
   logic signed [ACC_W-1:0] wt_ff [3];
   logic signed [tdfs_pkg::PROD_W-1:0] sum_ff;
   logic signed [15:0] res_ff [4];
   logic               covered_ff, written_ff, onscreen_ff;
   logic [ADDR_W-1:0]  addr_ff, clr_addr_ff;
   logic [15:0]        rd_q_ff;
   logic [15:0]        depth_mem [DEPTH_ENTRIES];

   logic signed [DW-1:0] ex [3];
   logic signed [DW-1:0] ey [3];
   logic signed [DW-1:0] pcx, pcy, edge_a, edge_b, mul_b;
   logic signed [ACC_W-1:0] mul_a;
   logic signed [tdfs_pkg::PROD_W-1:0] mul_p;
   logic [1:0]         mac_idx;
   logic [2:0]         tag;
   logic signed [ACC_W-1:0] w2, ca0, ca1, ca2, cd;
   logic               cov_now, nearer;
   logic signed [DIV_W-1:0] dx, num_s;
   logic [DIV_W-1:0]   div_num, div_den;
   logic               div_start, div_done;
   logic [tdfs_pkg::QUO_W-1:0] div_quo;
   logic signed [16:0] qv, qc;
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_wa;
   logic [15:0]        mem_wd;
   logic               edge_run, mac_run;
   logic [31:0]        idx_full;

   // pixel centre in 12.4
   assign pcx = $signed({3'b000, px_ff, 4'b1000});
   assign pcy = $signed({3'b000, py_ff, 4'b1000});

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ex[i] = {vx_ff[i][15], vx_ff[i]};
         ey[i] = {vy_ff[i][15], vy_ff[i]};
      end
   end

   always_comb begin
      case (step_ff)
         3'd0: begin edge_a = ex[1] - ex[0]; edge_b = ey[2] - ey[1]; end
         3'd1: begin edge_a = ey[0] - ey[1]; edge_b = ex[2] - ex[1]; end
         3'd2: begin edge_a = ex[1] - pcx;   edge_b = ey[2] - ey[1]; end
         3'd3: begin edge_a = pcy - ey[1];   edge_b = ex[2] - ex[1]; end
         3'd4: begin edge_a = ex[2] - pcx;   edge_b = ey[0] - ey[2]; end
         3'd5: begin edge_a = pcy - ey[2];   edge_b = ex[0] - ex[2]; end
         default: begin edge_a = '0; edge_b = '0; end
      endcase
   end

   assign mac_idx = (step_ff < 3'd3) ? step_ff[1:0] : 2'd0;

   always_comb begin
      if (state_ff == tdfs_pkg::ST_EDGE) begin
         mul_a = {{(ACC_W-DW){edge_a[DW-1]}}, edge_a};
         mul_b = edge_b;
      end else begin
         mul_a = wt_ff[mac_idx];
         case (ch_ff)
            tdfs_pkg::CH_DEPTH: mul_b = {vz_ff[mac_idx][15], vz_ff[mac_idx]};
            tdfs_pkg::CH_RED:   mul_b = {9'd0, cr_ff[mac_idx]};
            tdfs_pkg::CH_GREEN: mul_b = {9'd0, cg_ff[mac_idx]};
            default:            mul_b = {9'd0, cb_ff[mac_idx]};
         endcase
      end
   end

   assign mul_p = mul_a * mul_b;
   assign tag   = step_ff - 3'd1;

   // coverage over the normalised weights
   always_comb begin
      w2 = d_ff - w0_ff - w1_ff;
      if (d_ff < 0) begin
         cd = -d_ff; ca0 = -w0_ff; ca1 = -w1_ff; ca2 = -w2;
      end else begin
         cd = d_ff; ca0 = w0_ff; ca1 = w1_ff; ca2 = w2;
      end
      cov_now = (cd != '0) && (ca0 > 0) && (ca0 < cd) && (ca1 > 0) && (ca1 < cd)
                && (ca2 > 0) && (ca2 < cd);
   end

   // floor((2s + d) / 2d) offset so the numerator stays non-negative
   assign dx      = {{(DIV_W-ACC_W){dabs_ff[ACC_W-1]}}, dabs_ff};
   assign num_s   = ($signed(sum_ff[DIV_W-1:0]) <<< 1) + (dx <<< 16) + dx;
   assign div_num = num_s;
   assign div_den = dx <<< 1;

   assign qv = $signed({1'b0, div_quo}) - tdfs_pkg::QUO_OFFSET;
   always_comb begin
      if (ch_ff == tdfs_pkg::CH_DEPTH) begin
         if (qv > tdfs_pkg::FAR_DEPTH) qc = tdfs_pkg::FAR_DEPTH;
         else if (qv < tdfs_pkg::NEAR_DEPTH) qc = tdfs_pkg::NEAR_DEPTH;
         else qc = qv;
      end else begin
         if (qv > tdfs_pkg::COLOUR_MAX) qc = tdfs_pkg::COLOUR_MAX;
         else if (qv < 0) qc = '0;
         else qc = qv;
      end
   end

   assign nearer   = res_ff[0] < $signed(rd_q_ff);
   assign idx_full = 32'(head.pixel_y) * SCREEN_WIDTH + 32'(head.pixel_x);

   tdfs_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tdfs_pkg::ST_CLEAR:
            if (32'(clr_addr_ff) == DEPTH_ENTRIES - 1) state_in = tdfs_pkg::ST_IDLE;
         tdfs_pkg::ST_IDLE:
            if (head_valid && head.op == tdfs_pkg::OP_FRAG) state_in = tdfs_pkg::ST_EDGE;
         tdfs_pkg::ST_EDGE:
            if (step_ff == 3'd6) state_in = tdfs_pkg::ST_COVER;
         tdfs_pkg::ST_COVER:
            state_in = cov_now ? tdfs_pkg::ST_MAC : tdfs_pkg::ST_OUT;
         tdfs_pkg::ST_MAC:
            if (step_ff == 3'd3) state_in = tdfs_pkg::ST_DSTART;
         tdfs_pkg::ST_DSTART:
            state_in = tdfs_pkg::ST_DWAIT;
         tdfs_pkg::ST_DWAIT:
            if (div_done) begin
               if (ch_ff != tdfs_pkg::CH_BLUE) state_in = tdfs_pkg::ST_MAC;
               else if (onscreen_ff) state_in = tdfs_pkg::ST_MEMRD;
               else state_in = tdfs_pkg::ST_OUT;
            end
         tdfs_pkg::ST_MEMRD:
            state_in = tdfs_pkg::ST_MEMCMP;
         tdfs_pkg::ST_MEMCMP:
            state_in = tdfs_pkg::ST_OUT;
         tdfs_pkg::ST_OUT:
            if (!rsp_stall) state_in = tdfs_pkg::ST_IDLE;
         default:
            state_in = tdfs_pkg::ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      ctl.pop      = 1'b0;
      ctl.clearing = 1'b0;
      edge_run     = 1'b0;
      mac_run      = 1'b0;
      div_start    = 1'b0;
      rsp_valid    = 1'b0;
      mem_we       = 1'b0;
      mem_wa       = addr_ff;
      mem_wd       = res_ff[0];
      case (state_ff)
         tdfs_pkg::ST_CLEAR: begin
            ctl.clearing = 1'b1;
            mem_we       = 1'b1;
            mem_wa       = clr_addr_ff;
            mem_wd       = tdfs_pkg::FAR_WORD;
         end
         tdfs_pkg::ST_IDLE:   ctl.pop   = head_valid;
         tdfs_pkg::ST_EDGE:   edge_run  = 1'b1;
         tdfs_pkg::ST_MAC:    mac_run   = 1'b1;
         tdfs_pkg::ST_DSTART: div_start = 1'b1;
         tdfs_pkg::ST_MEMCMP: mem_we    = nearer;
         tdfs_pkg::ST_OUT:    rsp_valid = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= tdfs_pkg::ST_CLEAR;
         clr_addr_ff <= '0;
         step_ff     <= '0;
         ch_ff       <= '0;
         covered_ff  <= 1'b0;
         written_ff  <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            vx_ff[i] <= '0;
            vy_ff[i] <= '0;
            vz_ff[i] <= '0;
            cr_ff[i] <= '0;
            cg_ff[i] <= '0;
            cb_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (ctl.clearing) clr_addr_ff <= clr_addr_ff + 1'b1;
         if (ctl.pop && head.op == tdfs_pkg::OP_LOAD && head.vertex_index != 2'd3) begin
            vx_ff[head.vertex_index] <= head.vert_x;
            vy_ff[head.vertex_index] <= head.vert_y;
            vz_ff[head.vertex_index] <= head.vert_z;
            cr_ff[head.vertex_index] <= head.vert_red;
            cg_ff[head.vertex_index] <= head.vert_green;
            cb_ff[head.vertex_index] <= head.vert_blue;
         end
         case (state_ff)
            tdfs_pkg::ST_IDLE: begin
               step_ff    <= '0;
               ch_ff      <= '0;
               written_ff <= 1'b0;
            end
            tdfs_pkg::ST_EDGE: step_ff <= (step_ff == 3'd6) ? 3'd0 : step_ff + 3'd1;
            tdfs_pkg::ST_COVER: covered_ff <= cov_now;
            tdfs_pkg::ST_MAC: step_ff <= (step_ff == 3'd3) ? 3'd0 : step_ff + 3'd1;
            tdfs_pkg::ST_DWAIT: if (div_done) ch_ff <= ch_ff + 2'd1;
            tdfs_pkg::ST_MEMCMP: written_ff <= nearer;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_p;
      if (ctl.pop) begin
         px_ff       <= head.pixel_x;
         py_ff       <= head.pixel_y;
         onscreen_ff <= (32'(head.pixel_x) < SCREEN_WIDTH) && (32'(head.pixel_y) < SCREEN_HEIGHT);
         addr_ff     <= idx_full[ADDR_W-1:0];
      end
      if (edge_run) begin
         if (step_ff == 3'd0) begin
            d_ff  <= '0;
            w0_ff <= '0;
            w1_ff <= '0;
         end else begin
            case (tag[2:1])
               2'd0:    d_ff  <= d_ff + $signed(prod_ff[ACC_W-1:0]);
               2'd1:    w0_ff <= w0_ff + $signed(prod_ff[ACC_W-1:0]);
               default: w1_ff <= w1_ff + $signed(prod_ff[ACC_W-1:0]);
            endcase
         end
      end
      if (state_ff == tdfs_pkg::ST_COVER) begin
         dabs_ff  <= cd;
         wt_ff[0] <= ca0;
         wt_ff[1] <= ca1;
         wt_ff[2] <= ca2;
         for (int i = 0; i < 4; i++) res_ff[i] <= '0;
      end
      if (mac_run) begin
         if (step_ff == 3'd0) sum_ff <= '0;
         else sum_ff <= sum_ff + prod_ff;
      end
      if (state_ff == tdfs_pkg::ST_DWAIT && div_done) res_ff[ch_ff] <= qc[15:0];
   end

   always_ff @(posedge clock) begin
      if (mem_we) depth_mem[mem_wa] <= mem_wd;
      rd_q_ff <= depth_mem[addr_ff];
   end

   assign rsp_covered   = covered_ff;
   assign rsp_written   = written_ff;
   assign rsp_out_x     = px_ff;
   assign rsp_out_y     = py_ff;
   assign rsp_out_depth = res_ff[0];
   assign rsp_out_red   = res_ff[1][7:0];
   assign rsp_out_green = res_ff[2][7:0];
   assign rsp_out_blue  = res_ff[3][7:0];

endmodule

@@ rtl/core/triangle_fragment_depth_shader_core.sv @@
// Triangle fragment depth shader core: top level, front queue and back sequencer.
// Depends on tdfs_pkg, tdfs_front, tdfs_back.
// A covered fragment makes four channel passes through the 16-step divider, which set
//   most of its latency; an uncovered fragment skips them, and a vertex load is taken
//   into the vertex store in the back end's idle state.
// Throughput: one transaction at a time in the back end; the 2-entry queue takes more.
// Reset clears the vertices, then sweeps all SCREEN_WIDTH*SCREEN_HEIGHT depth buffer
//   entries with req_stall high.
module triangle_fragment_depth_shader_core #(
   parameter int SCREEN_WIDTH  = tdfs_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = tdfs_pkg::SCREEN_HEIGHT_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_op,
   input  logic [1:0]         req_vertex_index,
   input  logic signed [15:0] req_vert_x,
   input  logic signed [15:0] req_vert_y,
   input  logic signed [15:0] req_vert_z,
   input  logic [7:0]         req_vert_red,
   input  logic [7:0]         req_vert_green,
   input  logic [7:0]         req_vert_blue,
   input  logic [9:0]         req_pixel_x,
   input  logic [9:0]         req_pixel_y,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_covered,
   output logic               rsp_written,
   output logic [9:0]         rsp_out_x,
   output logic [9:0]         rsp_out_y,
   output logic [7:0]         rsp_out_red,
   output logic [7:0]         rsp_out_green,
   output logic [7:0]         rsp_out_blue,
   output logic signed [15:0] rsp_out_depth
);

   tdfs_pkg::item_type req_item, head;
   tdfs_pkg::ctl_type  ctl;
   logic               head_valid;

   always_comb begin
      req_item.op           = tdfs_pkg::op_type'(req_op);
      req_item.vertex_index = req_vertex_index;
      req_item.vert_x       = req_vert_x;
      req_item.vert_y       = req_vert_y;
      req_item.vert_z       = req_vert_z;
      req_item.vert_red     = req_vert_red;
      req_item.vert_green   = req_vert_green;
      req_item.vert_blue    = req_vert_blue;
      req_item.pixel_x      = req_pixel_x;
      req_item.pixel_y      = req_pixel_y;
   end

   tdfs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .ctl        (ctl),
      .head_valid (head_valid),
      .head       (head)
   );

   tdfs_back #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head          (head),
      .ctl           (ctl),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_covered   (rsp_covered),
      .rsp_written   (rsp_written),
      .rsp_out_x     (rsp_out_x),
      .rsp_out_y     (rsp_out_y),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue),
      .rsp_out_depth (rsp_out_depth)
   );

endmodule

@@ tb/sv/tb_top.sv @@
// Testbench for triangle_fragment_depth_shader_core: vertex loads and shaded fragments.
// Depends on tdfs_pkg and the core; a built-in predictor checks coverage, depth and colour.
`timescale 1ns / 1ps

module tb_top;

   localparam int IDLE_PCT   = 37;
   localparam int WATCH_LIM  = 4_000_000;
   localparam int DRAIN_CYC  = 300;
   localparam int HOLD_CYC   = 600;

   typedef struct packed {
      logic               covered;
      logic               written;
      logic [9:0]         px;
      logic [9:0]         py;
      logic [7:0]         red;
      logic [7:0]         green;
      logic [7:0]         blue;
      logic signed [15:0] depth;
   } shade_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_op = 1'b0;
   logic [1:0] req_vertex_index = '0;
   logic signed [15:0] req_vert_x = '0, req_vert_y = '0, req_vert_z = '0;
   logic [7:0] req_vert_red = '0, req_vert_green = '0, req_vert_blue = '0;
   logic [9:0] req_pixel_x = '0, req_pixel_y = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_covered, rsp_written;
   logic [9:0] rsp_out_x, rsp_out_y;
   logic [7:0] rsp_out_red, rsp_out_green, rsp_out_blue;
   logic signed [15:0] rsp_out_depth;

   tdfs_pkg::item_type pending[$];
   shade_type shades_due[$];
   logic signed [15:0] vx[3], vy[3], vz[3];
   logic [7:0] vr[3], vg[3], vb[3];
   logic signed [16:0] zbuf[int];
   int sent_cnt = 0, rsp_cnt = 0, covered_cnt = 0, written_cnt = 0;
   int mismatches = 0, idle_run = 0;
   int hold_left = 0;
   bit hold_done = 0;

   triangle_fragment_depth_shader_core uut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic longint round_div(longint s, longint d);
      longint n, m, q;
      n = 2 * s + d;
      m = 2 * d;
      q = n / m;
      if (n < 0 && (n % m) != 0) q = q - 1;
      return q;
   endfunction

   function automatic longint clampl(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic shade_type shade_fragment(logic [9:0] pxi, logic [9:0] pyi);
      shade_type s;
      longint x[3], y[3], w[3], px, py, d, zi;
      logic signed [16:0] stored;
      int idx;
      bit cov;
      for (int k = 0; k < 3; k++) begin
         x[k] = vx[k];
         y[k] = vy[k];
      end
      s = '0;
      s.px = pxi;
      s.py = pyi;
      px = longint'(pxi) * 16 + 8;
      py = longint'(pyi) * 16 + 8;
      d = -(x[0] - x[1]) * (y[2] - y[1]) + (y[0] - y[1]) * (x[2] - x[1]);
      w[0] = -(px - x[1]) * (y[2] - y[1]) + (py - y[1]) * (x[2] - x[1]);
      w[1] = -(px - x[2]) * (y[0] - y[2]) + (py - y[2]) * (x[0] - x[2]);
      w[2] = d - w[0] - w[1];
      if (d < 0) begin
         d = -d;
         for (int k = 0; k < 3; k++) w[k] = -w[k];
      end
      cov = (d != 0);
      for (int k = 0; k < 3; k++)
         if (!(w[k] > 0 && w[k] < d)) cov = 0;
      if (cov) begin
         zi = clampl(round_div(w[0] * vz[0] + w[1] * vz[1] + w[2] * vz[2], d),
                     -16384, 16384);
         s.covered = 1'b1;
         s.depth = zi[15:0];
         s.red   = 8'(clampl(round_div(w[0] * vr[0] + w[1] * vr[1] + w[2] * vr[2], d),
                             0, 255));
         s.green = 8'(clampl(round_div(w[0] * vg[0] + w[1] * vg[1] + w[2] * vg[2], d),
                             0, 255));
         s.blue  = 8'(clampl(round_div(w[0] * vb[0] + w[1] * vb[1] + w[2] * vb[2], d),
                             0, 255));
         idx = int'(pyi) * 1024 + int'(pxi);
         stored = zbuf.exists(idx) ? zbuf[idx] : tdfs_pkg::FAR_DEPTH;
         if (zi < stored) begin
            zbuf[idx] = zi[16:0];
            s.written = 1'b1;
         end
      end
      return s;
   endfunction

   task automatic add_load(int idx, int x, int y, int z, int r, int g, int b);
      tdfs_pkg::item_type it;
      it = '0;
      it.op = tdfs_pkg::OP_LOAD;
      it.vertex_index = idx[1:0];
      it.vert_x = x[15:0];
      it.vert_y = y[15:0];
      it.vert_z = z[15:0];
      it.vert_red = r[7:0];
      it.vert_green = g[7:0];
      it.vert_blue = b[7:0];
      it.pixel_x = 10'($urandom);
      it.pixel_y = 10'($urandom);
      pending = {pending, it};
   endtask

   task automatic add_frag(int px, int py);
      tdfs_pkg::item_type it;
      logic [127:0] raw;
      raw = {$urandom, $urandom, $urandom, $urandom};
      it = raw[$bits(tdfs_pkg::item_type)-1:0];
      it.op = tdfs_pkg::OP_FRAG;
      it.pixel_x = px[9:0];
      it.pixel_y = py[9:0];
      pending = {pending, it};
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (pending.size() > 0 &&
             ((sent_cnt >= 500 && sent_cnt < 700) || $urandom_range(99) >= IDLE_PCT)) begin
            tdfs_pkg::item_type it;
            it = pending.pop_front();
            req_op <= it.op;
            req_vertex_index <= it.vertex_index;
            req_vert_x <= it.vert_x;
            req_vert_y <= it.vert_y;
            req_vert_z <= it.vert_z;
            req_vert_red <= it.vert_red;
            req_vert_green <= it.vert_green;
            req_vert_blue <= it.vert_blue;
            req_pixel_x <= it.pixel_x;
            req_pixel_y <= it.pixel_y;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall, with one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (!hold_done && rsp_cnt >= 200) begin
         hold_done <= 1;
         hold_left <= HOLD_CYC;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !(sent_cnt >= 500 && sent_cnt < 700) && $urandom_range(99) < IDLE_PCT;
      end
   end

   // monitor, predictor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         bit moved;
         shade_type got, want;
         moved = 0;
         if (rsp_valid && !rsp_stall) begin
            moved = 1;
            rsp_cnt++;
            got = {rsp_covered, rsp_written, rsp_out_x, rsp_out_y,
                   rsp_out_red, rsp_out_green, rsp_out_blue, rsp_out_depth};
            if (shades_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected transaction %p", got);
            end else begin
               want = shades_due.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
               end
            end
         end
         if (req_valid && !req_stall) begin
            moved = 1;
            sent_cnt++;
            if (req_op == tdfs_pkg::OP_LOAD) begin
               if (req_vertex_index != 2'd3) begin
                  vx[req_vertex_index] = req_vert_x;
                  vy[req_vertex_index] = req_vert_y;
                  vz[req_vertex_index] = req_vert_z;
                  vr[req_vertex_index] = req_vert_red;
                  vg[req_vertex_index] = req_vert_green;
                  vb[req_vertex_index] = req_vert_blue;
               end
            end else begin
               want = shade_fragment(req_pixel_x, req_pixel_y);
               covered_cnt += want.covered;
               written_cnt += want.written;
               shades_due = {shades_due, want};
            end
         end
         idle_run = moved ? 0 : idle_run + 1;
         if (idle_run >= WATCH_LIM) begin
            $display("watchdog: no transaction for %0d cycles", idle_run);
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin
      int ax, ay, x[3], y[3], minx, maxx, miny, maxy, nf;
      for (int k = 0; k < 3; k++) begin
         vx[k] = '0; vy[k] = '0; vz[k] = '0;
         vr[k] = '0; vg[k] = '0; vb[k] = '0;
      end
      // directed: degenerate reset triangle, extremes, ignored index, depth retest
      add_frag(0, 0);
      add_frag(1023, 1023);
      add_load(3, 100, 100, 0, 255, 255, 255);
      add_frag(5, 5);
      add_load(0, 0, 0, -16384, 255, 0, 0);
      add_load(1, 16383, 0, -16384, 0, 255, 0);
      add_load(2, 0, 16383, -16384, 0, 0, 255);
      add_frag(0, 0);
      add_frag(10, 10);
      add_frag(10, 10);
      add_frag(511, 511);
      add_frag(1023, 0);
      add_load(0, 0, 0, 16384, 0, 0, 0);
      add_load(1, 16383, 0, 16384, 0, 0, 0);
      add_load(2, 16383, 16383, 16384, 255, 255, 255);
      add_frag(1000, 999);
      add_frag(20, 10);
      add_load(0, -32768, -32768, 0, 255, 255, 255);
      add_load(1, 32767, -32768, 0, 255, 255, 255);
      add_load(2, 0, 32767, 0, 255, 255, 255);
      add_frag(1023, 1023);
      add_frag(0, 1023);
      add_frag(512, 0);
      while (pending.size() + sent_cnt < 1150) begin
         if ($urandom_range(99) < 15) begin
            // noise: wild vertices, ignored loads, scattered pixels
            add_load($urandom_range(3), $urandom, $urandom, $urandom_range(65535) - 32768,
                     $urandom, $urandom, $urandom);
            add_frag($urandom_range(1023), $urandom_range(1023));
         end else begin
            if ($urandom_range(99) < 70) begin
               ax = 200 * $urandom_range(4);
               ay = 200 * $urandom_range(4);
            end else begin
               ax = $urandom_range(1000);
               ay = $urandom_range(1000);
            end
            for (int k = 0; k < 3; k++) begin
               x[k] = ax * 16 + $urandom_range(320);
               y[k] = ay * 16 + $urandom_range(320);
               add_load(k, x[k], y[k], $urandom_range(32768) - 16384,
                        $urandom, $urandom, $urandom);
            end
            minx = x[0]; maxx = x[0]; miny = y[0]; maxy = y[0];
            for (int k = 1; k < 3; k++) begin
               minx = x[k] < minx ? x[k] : minx;
               maxx = x[k] > maxx ? x[k] : maxx;
               miny = y[k] < miny ? y[k] : miny;
               maxy = y[k] > maxy ? y[k] : maxy;
            end
            nf = $urandom_range(6, 20);
            for (int f = 0; f < nf; f++)
               add_frag(int'(clampl($urandom_range(minx / 16, maxx / 16), 0, 1023)),
                        int'(clampl($urandom_range(miny / 16, maxy / 16), 0, 1023)));
         end
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      do @(posedge clock); while (pending.size() > 0 || req_valid);
      do @(posedge clock); while (shades_due.size() > 0);
      repeat (DRAIN_CYC) @(posedge clock);
      $display("run: %0d transactions in, %0d fragments shaded, %0d covered, %0d written",
               sent_cnt, rsp_cnt, covered_cnt, written_cnt);
      $display("mismatches: %0d", mismatches);
      if (mismatches == 0 && shades_due.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end
endmodule
